[hdl/bfgc_pkg.sv]
// shared types and constants for the glyph colorizer
package bfgc_pkg;

  localparam int ATLAS_DEPTH = 65536;
  localparam int ATLAS_AW    = $clog2(ATLAS_DEPTH);
  // wide enough for x + y * atlas_width at the largest register values
  localparam int IDX_W       = 27;
  localparam int CFG_AW      = 5;
  localparam int DIV_STEPS   = 11;

  // floor(s / 3) for s up to 765 as (s * 683) >> 11
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int         DIV3_SHIFT = 11;

  localparam logic [7:0] COV_FULL = 8'hFF;

  typedef enum logic [2:0] {
    REG_ATLAS_WIDTH  = 3'd0,
    REG_ATLAS_HEIGHT = 3'd1,
    REG_CELL_WIDTH   = 3'd2,
    REG_CELL_HEIGHT  = 3'd3,
    REG_FIRST_CODE   = 3'd4,
    REG_CHANNEL_MODE = 3'd5,
    REG_LOW_COLOR    = 3'd6,
    REG_HIGH_COLOR   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_AVG   = 2'd0,
    MODE_BLUE  = 2'd1,
    MODE_GREEN = 2'd2,
    MODE_RED   = 2'd3
  } chan_mode_t;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_RENDER = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_COORD = 2'd1,
    ST_LOAD  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    CALC_IDLE = 4'b0001,
    CALC_DIV  = 4'b0010,
    CALC_MUL  = 4'b0100,
    CALC_FIN  = 4'b1000
  } calc_state_t;

  typedef struct packed {
    action_t     action;
    status_t     status;
    logic        avg;
    logic [9:0]  lsum;
    logic [7:0]  lval;
    logic [5:0]  cx;
    logic [5:0]  cy;
    logic [7:0]  lv;
    logic [7:0]  q;
    logic [7:0]  rem;
    logic [14:0] x;
    logic [14:0] y;
    logic [25:0] prod;
    logic [IDX_W-1:0] idx;
  } item_t;

endpackage

[hdl/bfgc_ram.sv]
// generic single write port ram with registered read
module bfgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/bitmap_font_glyph_colorizer_unit.sv]
// glyph colorizer: coverage atlas load and per-pixel color blend pipeline
// one item per cycle sustained unless the output stalls or geometry is being derived
// a stalled output backs up stage by stage, empty stages still fill
// reset clears control state; atlas contents are undefined until loaded
// after reset and after any write to a geometry register (0 to 4) the input
// is held off through 11 serial divide steps, one multiply and one finish step
module bitmap_font_glyph_colorizer_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bfgc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       action,
  input  logic [15:0]                atlas_address,
  input  logic [7:0]                 blue_in,
  input  logic [7:0]                 green_in,
  input  logic [7:0]                 red_in,
  input  logic [7:0]                 char_code,
  input  logic [5:0]                 cell_x,
  input  logic [5:0]                 cell_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [31:0]                pixel_color,
  output logic [1:0]                 status
);

  // configuration registers
  logic [10:0] atlas_width;
  logic [10:0] atlas_height;
  logic [6:0]  cell_width;
  logic [6:0]  cell_height;
  logic [7:0]  first_code;
  bfgc_pkg::chan_mode_t channel_mode;
  logic [31:0] low_color;
  logic [31:0] high_color;

  logic               cfg_wr;
  bfgc_pkg::reg_idx_t cfg_idx;
  logic               geo_wr;

  // derived glyph geometry
  bfgc_pkg::calc_state_t calc_state;
  logic [3:0]  calc_step;
  logic [3:0]  bit_idx;
  logic [6:0]  wrem, wrem_next;
  logic [6:0]  hrem, hrem_next;
  logic [7:0]  wsh, hsh;
  logic        wq, hq;
  logic [10:0] cols, rows;
  logic [21:0] glyph_count;
  logic [21:0] atlas_area;
  logic [7:0]  lv_max;
  logic        glyphs_ok;

  // pipeline
  bfgc_pkg::item_t s1, s2, s3, s4, s5, s6;
  bfgc_pkg::item_t s1_next, s2_next, s3_next, s4_next, s5_next, s6_next;
  logic v1, v2, v3, v4, v5, v6, v7, v8;
  logic en1, en2, en3, en4, en5, en6, en7, en8, en9;
  logic in_fire;
  bfgc_pkg::action_t act7, act8;
  bfgc_pkg::status_t st7, st8;
  logic [3:0][15:0]  num8, num8_next;
  logic [31:0]       color9_next;
  logic              ram_we;
  logic [7:0]        cov;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = bfgc_pkg::reg_idx_t'(paddr[bfgc_pkg::CFG_AW-1:2]);

  always_comb begin
    case (cfg_idx) inside
      bfgc_pkg::REG_ATLAS_WIDTH, bfgc_pkg::REG_ATLAS_HEIGHT, bfgc_pkg::REG_CELL_WIDTH,
      bfgc_pkg::REG_CELL_HEIGHT, bfgc_pkg::REG_FIRST_CODE: begin
        geo_wr = cfg_wr;
      end
      default: begin
        geo_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      atlas_width  <= 11'd256;
      atlas_height <= 11'd256;
      cell_width   <= 7'd8;
      cell_height  <= 7'd16;
      first_code   <= 8'd32;
      channel_mode <= bfgc_pkg::MODE_AVG;
      low_color    <= 32'h0000_0000;
      high_color   <= 32'hFFFF_FFFF;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bfgc_pkg::REG_ATLAS_WIDTH:  atlas_width  <= pwdata[10:0];
        bfgc_pkg::REG_ATLAS_HEIGHT: atlas_height <= pwdata[10:0];
        bfgc_pkg::REG_CELL_WIDTH:   cell_width   <= pwdata[6:0];
        bfgc_pkg::REG_CELL_HEIGHT:  cell_height  <= pwdata[6:0];
        bfgc_pkg::REG_FIRST_CODE:   first_code   <= pwdata[7:0];
        bfgc_pkg::REG_CHANNEL_MODE: channel_mode <= bfgc_pkg::chan_mode_t'(pwdata[1:0]);
        bfgc_pkg::REG_LOW_COLOR:    low_color    <= pwdata;
        bfgc_pkg::REG_HIGH_COLOR:   high_color   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bfgc_pkg::REG_ATLAS_WIDTH:  prdata = {21'd0, atlas_width};
      bfgc_pkg::REG_ATLAS_HEIGHT: prdata = {21'd0, atlas_height};
      bfgc_pkg::REG_CELL_WIDTH:   prdata = {25'd0, cell_width};
      bfgc_pkg::REG_CELL_HEIGHT:  prdata = {25'd0, cell_height};
      bfgc_pkg::REG_FIRST_CODE:   prdata = {24'd0, first_code};
      bfgc_pkg::REG_CHANNEL_MODE: prdata = {30'd0, channel_mode};
      bfgc_pkg::REG_LOW_COLOR:    prdata = low_color;
      bfgc_pkg::REG_HIGH_COLOR:   prdata = high_color;
      default:                    prdata = 32'd0;
    endcase
  end

  // serial restoring division: columns and rows of glyphs, msb first
  assign bit_idx = 4'(bfgc_pkg::DIV_STEPS - 1) - calc_step;
  assign wsh     = {wrem, atlas_width[bit_idx]};
  assign hsh     = {hrem, atlas_height[bit_idx]};
  assign wq      = wsh >= {1'b0, cell_width};
  assign hq      = hsh >= {1'b0, cell_height};
  assign wrem_next = wq ? 7'(wsh - {1'b0, cell_width}) : wsh[6:0];
  assign hrem_next = hq ? 7'(hsh - {1'b0, cell_height}) : hsh[6:0];

  always_ff @(posedge clk) begin
    if (rst || geo_wr) begin
      calc_state <= bfgc_pkg::CALC_DIV;
      calc_step  <= 4'd0;
      wrem       <= 7'd0;
      hrem       <= 7'd0;
    end else begin
      unique case (calc_state)
        bfgc_pkg::CALC_IDLE: begin
        end
        bfgc_pkg::CALC_DIV: begin
          wrem      <= wrem_next;
          hrem      <= hrem_next;
          cols      <= {cols[9:0], wq};
          rows      <= {rows[9:0], hq};
          calc_step <= calc_step + 4'd1;
          if (calc_step == 4'(bfgc_pkg::DIV_STEPS - 1)) begin
            calc_state <= bfgc_pkg::CALC_MUL;
          end
        end
        bfgc_pkg::CALC_MUL: begin
          glyph_count <= 22'(cols) * 22'(rows);
          atlas_area  <= 22'(atlas_width) * 22'(atlas_height);
          calc_state  <= bfgc_pkg::CALC_FIN;
        end
        bfgc_pkg::CALC_FIN: begin
          // a zero cell size makes the serial quotient meaningless
          glyphs_ok  <= (cell_width != 7'd0) && (cell_height != 7'd0) &&
                        (glyph_count != 22'd0);
          lv_max     <= (glyph_count > 22'd256) ? 8'hFF : 8'(glyph_count - 22'd1);
          calc_state <= bfgc_pkg::CALC_IDLE;
        end
        default: begin
          calc_state <= bfgc_pkg::CALC_IDLE;
        end
      endcase
    end
  end

  // stage enables: a stage moves when it is empty or its successor moves
  assign en9 = !out_valid || out_ready;
  assign en8 = !v8 || en9;
  assign en7 = !v7 || en8;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign in_ready = en1 && (calc_state == bfgc_pkg::CALC_IDLE);
  assign in_fire  = in_valid && in_ready;

  // four restoring divide steps of the glyph index by the column count
  function automatic logic [15:0] div4(input logic [7:0] rem_in, input logic [7:0] q_in,
                                       input logic [3:0] bits, input logic [10:0] dvs);
    logic [7:0] r;
    logic [7:0] q;
    logic [8:0] t;
    r = rem_in;
    q = q_in;
    for (int i = 0; i < 4; i++) begin
      t = {r, bits[2'(3 - i)]};
      if (11'(t) >= dvs) begin
        r = 8'(11'(t) - dvs);
        q = {q[6:0], 1'b1};
      end else begin
        r = t[7:0];
        q = {q[6:0], 1'b0};
      end
    end
    return {q, r};
  endfunction

  // stage 1: clamp code to glyph range, reduce load pixel, check load address
  always_comb begin
    logic [7:0] d;
    s1_next        = '0;
    s1_next.action = bfgc_pkg::action_t'(action);
    s1_next.cx     = cell_x;
    s1_next.cy     = cell_y;
    s1_next.idx    = bfgc_pkg::IDX_W'(atlas_address);
    case (channel_mode)
      bfgc_pkg::MODE_AVG: begin
        s1_next.avg  = 1'b1;
        s1_next.lsum = 10'(blue_in) + 10'(green_in) + 10'(red_in);
      end
      bfgc_pkg::MODE_BLUE:  s1_next.lsum = 10'(blue_in);
      bfgc_pkg::MODE_GREEN: s1_next.lsum = 10'(green_in);
      default:              s1_next.lsum = 10'(red_in);
    endcase
    d = char_code - first_code;
    if (char_code < first_code) begin
      s1_next.lv = 8'd0;
    end else if (d > lv_max) begin
      s1_next.lv = lv_max;
    end else begin
      s1_next.lv = d;
    end
    if (s1_next.action == bfgc_pkg::ACT_LOAD) begin
      if (s1_next.idx >= bfgc_pkg::IDX_W'(atlas_area) ||
          s1_next.idx >= bfgc_pkg::IDX_W'(bfgc_pkg::ATLAS_DEPTH)) begin
        s1_next.status = bfgc_pkg::ST_LOAD;
      end else begin
        s1_next.status = bfgc_pkg::ST_OK;
      end
    end else begin
      s1_next.status = glyphs_ok ? bfgc_pkg::ST_OK : bfgc_pkg::ST_COORD;
    end
  end

  // stage 2: upper half of glyph index division, finish load coverage byte
  always_comb begin
    logic [19:0] p3;
    s2_next = s1;
    {s2_next.q, s2_next.rem} = div4(8'd0, 8'd0, s1.lv[7:4], cols);
    p3 = 20'(s1.lsum) * 20'(bfgc_pkg::DIV3_MUL);
    s2_next.lval = s1.avg ? 8'(p3 >> bfgc_pkg::DIV3_SHIFT) : s1.lsum[7:0];
  end

  // stage 3: lower half of the division
  always_comb begin
    s3_next = s2;
    {s3_next.q, s3_next.rem} = div4(s2.rem, s2.q, s2.lv[3:0], cols);
  end

  // stage 4: atlas coordinates of the pixel
  always_comb begin
    s4_next   = s3;
    s4_next.x = 15'(s3.cx) + 15'(s3.rem) * 15'(cell_width);
    s4_next.y = 15'(s3.cy) + 15'(s3.q) * 15'(cell_height);
  end

  // stage 5: bounds check and row offset
  always_comb begin
    s5_next      = s4;
    s5_next.prod = 26'(s4.y) * 26'(atlas_width);
    if (s4.action == bfgc_pkg::ACT_RENDER &&
        (s4.x >= 15'(atlas_width) || s4.y >= 15'(atlas_height))) begin
      s5_next.status = bfgc_pkg::ST_COORD;
    end
  end

  // stage 6: linear atlas index
  always_comb begin
    s6_next = s5;
    if (s5.action == bfgc_pkg::ACT_RENDER) begin
      s6_next.idx = bfgc_pkg::IDX_W'(s5.x) + bfgc_pkg::IDX_W'(s5.prod);
      if (s6_next.idx >= bfgc_pkg::IDX_W'(bfgc_pkg::ATLAS_DEPTH)) begin
        s6_next.status = bfgc_pkg::ST_COORD;
      end
    end
  end

  // loads write and renders read at the same stage, so atlas order follows item order
  assign ram_we = en7 && v6 && s6.action == bfgc_pkg::ACT_LOAD && s6.status == bfgc_pkg::ST_OK;

  bfgc_ram #(
    .WIDTH(8),
    .DEPTH(bfgc_pkg::ATLAS_DEPTH)
  ) u_atlas (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s6.idx[bfgc_pkg::ATLAS_AW-1:0]),
    .wdata(s6.lval),
    .re   (en7),
    .raddr(s6.idx[bfgc_pkg::ATLAS_AW-1:0]),
    .rdata(cov)
  );

  // stage 8: per channel numerator lo*(255-cov) + hi*cov
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      num8_next[k] = 16'(low_color[8*k +: 8]) * 16'(bfgc_pkg::COV_FULL - cov) +
                     16'(high_color[8*k +: 8]) * 16'(cov);
    end
  end

  // stage 9: exact floor division by 255 for numerators below 65280
  always_comb begin
    logic [16:0] t;
    color9_next = 32'd0;
    for (int k = 0; k < 4; k++) begin
      t = 17'(num8[k]) + 17'(num8[k] >> 8) + 17'd1;
      color9_next[8*k +: 8] = t[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_fire;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
      if (en8) v8 <= v7;
      if (en9) out_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
    if (en4) s4 <= s4_next;
    if (en5) s5 <= s5_next;
    if (en6) s6 <= s6_next;
    if (en7) begin
      act7 <= s6.action;
      st7  <= s6.status;
    end
    if (en8) begin
      act8 <= act7;
      st8  <= st7;
      num8 <= num8_next;
    end
    if (en9) begin
      status      <= st8;
      pixel_color <= (act8 == bfgc_pkg::ACT_RENDER && st8 == bfgc_pkg::ST_OK) ?
                     color9_next : 32'd0;
    end
  end

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    calc_state != bfgc_pkg::CALC_IDLE |-> !in_ready)
    else $error("input taken while glyph geometry is being derived");

  a_geo_write_restarts: assert property (@(posedge clk) disable iff (rst)
    geo_wr |=> calc_state == bfgc_pkg::CALC_DIV && calc_step == 4'd0)
    else $error("geometry write did not restart the derivation");

  a_error_color_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != bfgc_pkg::ST_OK |-> pixel_color == 32'd0)
    else $error("result with error status carries a color");

endmodule

[dv/tb.sv]
// testbench for the glyph colorizer: directed and random loads and renders, scoreboard check
`timescale 1ns / 100ps

module tb;
  import bfgc_pkg::*;

  typedef struct packed {
    action_t    act;
    logic [15:0] addr;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] code;
    logic [5:0] cx;
    logic [5:0] cy;
  } glyph_req_t;

  typedef struct packed {
    logic [31:0] color;
    status_t     st;
  } pixel_res_t;

  // colorizer model with its own copy of the registers and the atlas
  class glyph_scoreboard;
    logic [10:0] aw, ah;
    logic [6:0]  cw, ch;
    logic [7:0]  fc;
    chan_mode_t  mode;
    logic [31:0] lo_c, hi_c;
    logic [7:0]  coverage [ATLAS_DEPTH];
    pixel_res_t  pixel_q [$];
    int          errors;

    function new();
      aw     = 11'd256;
      ah     = 11'd256;
      cw     = 7'd8;
      ch     = 7'd16;
      fc     = 8'd32;
      mode   = MODE_AVG;
      lo_c   = 32'h0000_0000;
      hi_c   = 32'hFFFF_FFFF;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        REG_ATLAS_WIDTH:  aw = v[10:0];
        REG_ATLAS_HEIGHT: ah = v[10:0];
        REG_CELL_WIDTH:   cw = v[6:0];
        REG_CELL_HEIGHT:  ch = v[6:0];
        REG_FIRST_CODE:   fc = v[7:0];
        REG_CHANNEL_MODE: mode = chan_mode_t'(v[1:0]);
        REG_LOW_COLOR:    lo_c = v;
        default:          hi_c = v;
      endcase
    endfunction

    function int unsigned load_limit();
      int unsigned area;
      area = aw * ah;
      return (area > ATLAS_DEPTH) ? ATLAS_DEPTH : area;
    endfunction

    function bit load_in_range(logic [15:0] addr);
      return 32'(addr) < load_limit();
    endfunction

    // atlas pixel read by a render, or -1 when the render reads nothing
    function int atlas_index(logic [7:0] code_in, logic [5:0] cx, logic [5:0] cy);
      int unsigned cols, rows, count, code, last, lv, x, y, idx;
      if (cw == 0 || ch == 0) return -1;
      cols  = aw / cw;
      rows  = ah / ch;
      count = cols * rows;
      if (count == 0) return -1;
      code = code_in;
      last = fc + count - 1;
      if (code < fc) code = fc;
      if (code > last) code = last;
      lv  = code - fc;
      x   = cx + (lv % cols) * cw;
      y   = cy + (lv / cols) * ch;
      idx = x + y * aw;
      if (x >= aw || y >= ah || idx >= ATLAS_DEPTH) return -1;
      return int'(idx);
    endfunction

    function logic [31:0] blend(logic [7:0] c);
      logic [31:0] res;
      int unsigned lo, hi, num;
      res = '0;
      for (int k = 0; k < 4; k++) begin
        lo  = (lo_c >> (8 * k)) & 32'hFF;
        hi  = (hi_c >> (8 * k)) & 32'hFF;
        num = lo * 255 + hi * c - lo * c;
        res[8*k +: 8] = 8'(num / 255);
      end
      return res;
    endfunction

    function void note_input(glyph_req_t q);
      pixel_res_t  e;
      int unsigned s;
      int          idx;
      e.color = '0;
      e.st    = ST_OK;
      if (q.act == ACT_LOAD) begin
        s = q.b + q.g + q.r;
        case (mode)
          MODE_AVG:   s = s / 3;
          MODE_BLUE:  s = q.b;
          MODE_GREEN: s = q.g;
          default:    s = q.r;
        endcase
        if (load_in_range(q.addr)) coverage[q.addr] = s[7:0];
        else e.st = ST_LOAD;
      end else begin
        idx = atlas_index(q.code, q.cx, q.cy);
        if (idx < 0) e.st = ST_COORD;
        else e.color = blend(coverage[idx]);
      end
      pixel_q.push_back(e);
    endfunction

    task report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, exp_v, got_v);
      errors++;
    endtask

    task check_result(logic [31:0] color, logic [1:0] st);
      pixel_res_t e;
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected transfer", 32'h0, color);
      end else begin
        e = pixel_q.pop_front();
        if (color !== e.color) report_mismatch("pixel_color", e.color, color);
        if (st !== e.st) report_mismatch("status", 32'(e.st), 32'(st));
      end
    endtask

    function int pending();
      return pixel_q.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_AW-1:0]        paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  action_t                  action = ACT_LOAD;
  logic [15:0]              atlas_address = '0;
  logic [7:0]               blue_in = '0;
  logic [7:0]               green_in = '0;
  logic [7:0]               red_in = '0;
  logic [7:0]               char_code = '0;
  logic [5:0]               cell_x = '0;
  logic [5:0]               cell_y = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [31:0]              pixel_color;
  logic [1:0]               status;

  glyph_scoreboard sb = new();
  bit  atlas_written [ATLAS_DEPTH];
  bit  no_gaps = 1'b0;
  int  hold_cycles = 0;

  bitmap_font_glyph_colorizer_unit i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  always begin
    @(posedge clk);
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      repeat (hold_cycles) @(posedge clk);
      hold_cycles = 0;
    end
    out_ready <= no_gaps || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(pixel_color, status);
      if (in_valid && in_ready)
        sb.note_input(glyph_req_t'({action, atlas_address, blue_in, green_in, red_in,
                                    char_code, cell_x, cell_y}));
    end
  end

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(r, v);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_geometry(int unsigned aw, ah, cw, ch, fc, chan_mode_t mode,
                              logic [31:0] lo, hi);
    drain();
    write_reg(REG_ATLAS_WIDTH, aw);
    write_reg(REG_ATLAS_HEIGHT, ah);
    write_reg(REG_CELL_WIDTH, cw);
    write_reg(REG_CELL_HEIGHT, ch);
    write_reg(REG_FIRST_CODE, fc);
    write_reg(REG_CHANNEL_MODE, 32'(mode));
    write_reg(REG_LOW_COLOR, lo);
    write_reg(REG_HIGH_COLOR, hi);
  endtask

  task automatic send_item(glyph_req_t q);
    if (!no_gaps) begin
      while ($urandom_range(99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    action        <= q.act;
    atlas_address <= q.addr;
    blue_in       <= q.b;
    green_in      <= q.g;
    red_in        <= q.r;
    char_code     <= q.code;
    cell_x        <= q.cx;
    cell_y        <= q.cy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic glyph_req_t rand_item();
    glyph_req_t q;
    q.act  = ($urandom_range(99) < 35) ? ACT_LOAD : ACT_RENDER;
    q.addr = 16'($urandom);
    q.b    = 8'($urandom);
    q.g    = 8'($urandom);
    q.r    = 8'($urandom);
    q.code = 8'($urandom);
    q.cx   = 6'($urandom);
    q.cy   = 6'($urandom);
    if (q.act == ACT_LOAD) begin
      if ($urandom_range(3) != 0) q.addr = 16'($urandom_range(sb.load_limit() - 1));
    end else begin
      // mostly codes near the glyph range and offsets inside the cell
      if ($urandom_range(1) != 0) q.code = sb.fc + 8'($urandom_range(15));
      if ($urandom_range(3) != 0) q.cx = 6'($urandom_range(sb.cw - 1));
      if ($urandom_range(3) != 0) q.cy = 6'($urandom_range(sb.ch - 1));
    end
    return q;
  endfunction

  function automatic glyph_req_t mk(action_t a, logic [15:0] addr, logic [7:0] b, g, r, code,
                                    logic [5:0] cx, cy);
    glyph_req_t q;
    q.act  = a;
    q.addr = addr;
    q.b    = b;
    q.g    = g;
    q.r    = r;
    q.code = code;
    q.cx   = cx;
    q.cy   = cy;
    return q;
  endfunction

  // a render of a never loaded pixel is preceded by a load of that pixel
  task automatic issue(glyph_req_t q);
    glyph_req_t fill;
    int         idx;
    if (q.act == ACT_RENDER) begin
      idx = sb.atlas_index(q.code, q.cx, q.cy);
      if (idx >= 0 && !atlas_written[idx]) begin
        fill      = rand_item();
        fill.act  = ACT_LOAD;
        fill.addr = 16'(idx);
        send_item(fill);
        atlas_written[idx] = 1'b1;
      end
    end else if (sb.load_in_range(q.addr)) begin
      atlas_written[q.addr] = 1'b1;
    end
    send_item(q);
  endtask

  task automatic run_random(int n);
    repeat (n) issue(rand_item());
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: 256x256 atlas, 8x16 cells, first code 32, average mode
    issue(mk(ACT_LOAD, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 6'd0, 6'd0));
    issue(mk(ACT_LOAD, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'h3F, 6'h3F));
    issue(mk(ACT_LOAD, 16'd1, 8'hFF, 8'hFF, 8'hFE, 8'h00, 6'd0, 6'd0));
    issue(mk(ACT_LOAD, 16'd2, 8'h01, 8'h01, 8'h00, 8'h00, 6'd0, 6'd0));
    issue(mk(ACT_LOAD, 16'd3, 8'h80, 8'h40, 8'h01, 8'h00, 6'd0, 6'd0));
    // code below the first glyph
    issue(mk(ACT_RENDER, 16'd0, 8'h00, 8'h00, 8'h00, 8'd0, 6'd0, 6'd0));
    issue(mk(ACT_RENDER, 16'd0, 8'h00, 8'h00, 8'h00, 8'd32, 6'd1, 6'd0));
    issue(mk(ACT_RENDER, 16'd0, 8'h00, 8'h00, 8'h00, 8'd32, 6'd2, 6'd0));
    issue(mk(ACT_RENDER, 16'd0, 8'h00, 8'h00, 8'h00, 8'd32, 6'd3, 6'd0));
    issue(mk(ACT_RENDER, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'd255, 6'd7, 6'd15));
    // offset past the right edge of the atlas
    issue(mk(ACT_RENDER, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'd255, 6'd63, 6'd63));
    // offset reaching into the neighboring cell
    issue(mk(ACT_RENDER, 16'd0, 8'h00, 8'h00, 8'h00, 8'd33, 6'd63, 6'd0));
    issue(mk(ACT_RENDER, 16'd0, 8'h00, 8'h00, 8'h00, 8'd32, 6'd0, 6'd63));
    run_random(100);

    // 1024x1024 atlas with 64x64 cells: the atlas depth bounds the index
    set_geometry(1024, 1024, 64, 64, 0, MODE_BLUE, 32'h0000_0000, 32'hFFFF_FFFF);
    hold_cycles = 90;
    run_random(110);

    // one pixel atlas, one glyph at the last code
    set_geometry(1, 1, 1, 1, 255, MODE_GREEN, $urandom, $urandom);
    run_random(60);

    // four glyphs: codes above the last one clamp, colors run downward
    set_geometry(8, 8, 4, 4, 0, MODE_RED, 32'hFFFF_FFFF, 32'h0000_0000);
    run_random(80);

    // cell larger than the atlas: no glyphs
    set_geometry(16, 16, 32, 32, 7, MODE_AVG, $urandom, $urandom);
    run_random(50);

    no_gaps = 1'b1;
    set_geometry(1024, 64, 1, 1, 200, MODE_AVG, $urandom, $urandom);
    run_random(120);
    no_gaps = 1'b0;

    repeat (5) begin
      set_geometry($urandom_range(400, 8), $urandom_range(400, 8), $urandom_range(24, 1),
                   $urandom_range(24, 1), $urandom_range(255), chan_mode_t'($urandom_range(3)),
                   $urandom, $urandom);
      if ($urandom_range(1) != 0) hold_cycles = 60;
      run_random(80);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[bitmap_font_glyph_colorizer_unit.f]
hdl/bfgc_pkg.sv
hdl/bfgc_ram.sv
hdl/bitmap_font_glyph_colorizer_unit.sv
dv/tb.sv
